### design/qvr_pkg.sv
// Package for the quaternion vector rotate unit: widths, CORDIC constants,
// arctangent table and pipeline record types. No dependencies.
package qvr_pkg;

	localparam int AngleW = 17;
	localparam int AxisW = 16;
	localparam int VecW = 32;
	localparam int TrigIterDefault = 16;
	localparam int AtanEntries = 24;
	localparam int QuarterTurn = 23040;
	localparam int HalfTurn = 46080;
	// CORDIC datapath: Q30 values with headroom
	localparam int CordW = 33;
	// angle accumulator, degrees Q.24 (half angle up to 90 deg plus slack)
	localparam int ZW = 32;
	localparam logic signed [CordW-1:0] InvGainQ30 = 33'sd652032874;
	// quaternion parts Q24, |q| up to 2*2^24 for a Q2.14 axis
	localparam int QW = 27;
	// first product rounded to Q16: 32-bit vector times 2-ish gain, slack
	localparam int TW = 36;

	typedef logic signed [ZW-1:0] atan_t;

	function automatic atan_t atan_lut(input logic [4:0] idx);
		atan_t r;
		r = '0;
		case (idx)
			5'd0: r = 32'sd754974720;
			5'd1: r = 32'sd445687602;
			5'd2: r = 32'sd235489088;
			5'd3: r = 32'sd119537938;
			5'd4: r = 32'sd60000934;
			5'd5: r = 32'sd30029717;
			5'd6: r = 32'sd15018523;
			5'd7: r = 32'sd7509720;
			5'd8: r = 32'sd3754917;
			5'd9: r = 32'sd1877466;
			5'd10: r = 32'sd938734;
			5'd11: r = 32'sd469367;
			5'd12: r = 32'sd234684;
			5'd13: r = 32'sd117342;
			5'd14: r = 32'sd58671;
			5'd15: r = 32'sd29335;
			5'd16: r = 32'sd14668;
			5'd17: r = 32'sd7334;
			5'd18: r = 32'sd3667;
			5'd19: r = 32'sd1833;
			5'd20: r = 32'sd917;
			5'd21: r = 32'sd458;
			5'd22: r = 32'sd229;
			5'd23: r = 32'sd115;
			default: r = '0;
		endcase
		return r;
	endfunction

	typedef struct packed {
		logic signed [CordW-1:0] x;
		logic signed [CordW-1:0] y;
		logic signed [ZW-1:0] z;
		logic neg;
	} cord_t;

	typedef struct packed {
		logic signed [AxisW-1:0] ax;
		logic signed [AxisW-1:0] ay;
		logic signed [AxisW-1:0] az;
		logic signed [VecW-1:0] vx;
		logic signed [VecW-1:0] vy;
		logic signed [VecW-1:0] vz;
	} carry_t;

endpackage

### design/qvr_cordic.sv
// Pipelined rotation-mode CORDIC: one register stage per iteration.
// Depends on qvr_pkg.
module qvr_cordic #(
	parameter int TRIG_ITERATIONS = qvr_pkg::TrigIterDefault
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic signed [qvr_pkg::AngleW-1:0] angle,
	input  qvr_pkg::carry_t        in_carry,
	output logic                   out_valid,
	output logic signed [qvr_pkg::CordW-1:0] sin_o,
	output logic signed [qvr_pkg::CordW-1:0] cos_o,
	output qvr_pkg::carry_t        out_carry
);
	import qvr_pkg::*;

	localparam int N = (TRIG_ITERATIONS < AtanEntries) ? TRIG_ITERATIONS : AtanEntries;

	cord_t  st_s1 [N+1];
	carry_t cy_s1 [N+1];
	logic   vl_s1 [N+1];

	// range fold, registered as entry stage
	logic signed [AngleW:0] h_fold;
	logic neg_in;
	always_comb begin
		h_fold = {angle[AngleW-1], angle};
		neg_in = 1'b0;
		if (angle > $signed(AngleW'(QuarterTurn))) begin
			h_fold = h_fold - (AngleW+1)'(HalfTurn);
			neg_in = 1'b1;
		end else if (angle < -$signed(AngleW'(QuarterTurn))) begin
			h_fold = h_fold + (AngleW+1)'(HalfTurn);
			neg_in = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vl_s1[0] <= 1'b0;
		else vl_s1[0] <= in_valid;
	end
	always_ff @(posedge clk) begin
		st_s1[0].x <= InvGainQ30;
		st_s1[0].y <= '0;
		st_s1[0].z <= ZW'(h_fold) <<< 16;
		st_s1[0].neg <= neg_in;
		cy_s1[0] <= in_carry;
	end

	for (genvar i = 0; i < N; i++) begin : g_it
		cord_t nx;
		always_comb begin
			nx = st_s1[i];
			if (!st_s1[i].z[ZW-1]) begin
				nx.x = st_s1[i].x - (st_s1[i].y >>> i);
				nx.y = st_s1[i].y + (st_s1[i].x >>> i);
				nx.z = st_s1[i].z - atan_lut(5'(i));
			end else begin
				nx.x = st_s1[i].x + (st_s1[i].y >>> i);
				nx.y = st_s1[i].y - (st_s1[i].x >>> i);
				nx.z = st_s1[i].z + atan_lut(5'(i));
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vl_s1[i+1] <= 1'b0;
			else vl_s1[i+1] <= vl_s1[i];
		end
		always_ff @(posedge clk) begin
			st_s1[i+1] <= nx;
			cy_s1[i+1] <= cy_s1[i];
		end
	end

	assign out_valid = vl_s1[N];
	assign sin_o = st_s1[N].neg ? -st_s1[N].y : st_s1[N].y;
	assign cos_o = st_s1[N].neg ? -st_s1[N].x : st_s1[N].x;
	assign out_carry = cy_s1[N];

`ifndef NO_ASSERTIONS
	a_fold_range: assert property (@(posedge clk) disable iff (!arst_n)
		vl_s1[0] |-> (st_s1[0].z <= (ZW'(QuarterTurn) <<< 16)
			&& st_s1[0].z >= -(ZW'(QuarterTurn) <<< 16)))
		else $error("folded angle out of range");
	a_valid_flow: assert property (@(posedge clk) disable iff (!arst_n)
		vl_s1[0] |-> ##(N) out_valid)
		else $error("valid lost in cordic");
	a_gain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (st_s1[N].x < 33'sd1200000000 && st_s1[N].x > -33'sd1200000000))
		else $error("cordic x out of bound");
`endif
endmodule

### design/qvr_qmul.sv
// Two quaternion products q*v and t*conj(q), staged with a register after
// every multiply and every sum. Depends on qvr_pkg.
module qvr_qmul (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic signed [qvr_pkg::CordW-1:0] sin_i,
	input  logic signed [qvr_pkg::CordW-1:0] cos_i,
	input  qvr_pkg::carry_t        in_carry,
	output logic                   out_valid,
	output logic signed [qvr_pkg::VecW-1:0] rx,
	output logic signed [qvr_pkg::VecW-1:0] ry,
	output logic signed [qvr_pkg::VecW-1:0] rz
);
	import qvr_pkg::*;

	localparam int PW = QW + VecW;     // q times vector
	localparam int P2 = QW + TW;       // q times t
	localparam int SW = P2 + 3;

	logic [6:0] vl_q;
	// stage 1: axis*sin products
	logic signed [AxisW+CordW-1:0] px_s1, py_s1, pz_s1;
	logic signed [CordW-1:0] c_s1;
	logic signed [VecW-1:0] vx_s1, vy_s1, vz_s1;
	// stage 2: rounded quaternion
	logic signed [QW-1:0] qx_s2, qy_s2, qz_s2, qw_s2;
	logic signed [VecW-1:0] vx_s2, vy_s2, vz_s2;
	// stage 3: q*v partial products
	logic signed [PW-1:0] m_s3 [12];
	logic signed [QW-1:0] qx_s3, qy_s3, qz_s3, qw_s3;
	// stage 4: t rounded
	logic signed [TW-1:0] tw_s4, tx_s4, ty_s4, tz_s4;
	logic signed [QW-1:0] qx_s4, qy_s4, qz_s4, qw_s4;
	// stage 5: t*conj(q) partial products
	logic signed [P2-1:0] n_s5 [12];
	// stage 6: rounded sums
	logic signed [SW-24-1:0] rx_s6, ry_s6, rz_s6;

	function automatic logic signed [SW-1:0] rnd_add(input logic signed [SW-1:0] v);
		return v + (SW'(1) <<< 23);
	endfunction

	function automatic logic signed [VecW-1:0] sat(input logic signed [SW-24-1:0] v);
		logic signed [SW-24-1:0] hi, lo;
		hi = (SW-24)'(32'sh7fffffff);
		lo = -(SW-24)'(33'sh80000000);
		if (v > hi) return 32'sh7fffffff;
		if (v < lo) return 32'sh80000000;
		return VecW'(v);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vl_q <= '0;
		else vl_q <= {vl_q[5:0], in_valid};
	end

	logic signed [AxisW+CordW-1:0] h20;
	logic signed [CordW-1:0] h6;
	logic signed [SW-1:0] tws, txs, tys, tzs, rxs, rys, rzs;
	always_comb begin
		h20 = (AxisW+CordW)'(1) <<< 19;
		h6 = CordW'(32);
		tws = -SW'(m_s3[0]) - SW'(m_s3[1]) - SW'(m_s3[2]);
		txs = SW'(m_s3[3]) + SW'(m_s3[4]) - SW'(m_s3[5]);
		tys = SW'(m_s3[6]) + SW'(m_s3[7]) - SW'(m_s3[8]);
		tzs = SW'(m_s3[9]) + SW'(m_s3[10]) - SW'(m_s3[11]);
		rxs = SW'(n_s5[0]) - SW'(n_s5[1]) - SW'(n_s5[2]) + SW'(n_s5[3]);
		rys = SW'(n_s5[4]) - SW'(n_s5[5]) - SW'(n_s5[6]) + SW'(n_s5[7]);
		rzs = SW'(n_s5[8]) - SW'(n_s5[9]) - SW'(n_s5[10]) + SW'(n_s5[11]);
	end

	always_ff @(posedge clk) begin
		px_s1 <= in_carry.ax * sin_i;
		py_s1 <= in_carry.ay * sin_i;
		pz_s1 <= in_carry.az * sin_i;
		c_s1 <= cos_i;
		vx_s1 <= in_carry.vx;
		vy_s1 <= in_carry.vy;
		vz_s1 <= in_carry.vz;

		qx_s2 <= QW'((px_s1 + h20) >>> 20);
		qy_s2 <= QW'((py_s1 + h20) >>> 20);
		qz_s2 <= QW'((pz_s1 + h20) >>> 20);
		qw_s2 <= QW'((c_s1 + h6) >>> 6);
		vx_s2 <= vx_s1;
		vy_s2 <= vy_s1;
		vz_s2 <= vz_s1;

		m_s3[0] <= qx_s2 * vx_s2;
		m_s3[1] <= qy_s2 * vy_s2;
		m_s3[2] <= qz_s2 * vz_s2;
		m_s3[3] <= qw_s2 * vx_s2;
		m_s3[4] <= qy_s2 * vz_s2;
		m_s3[5] <= qz_s2 * vy_s2;
		m_s3[6] <= qw_s2 * vy_s2;
		m_s3[7] <= qz_s2 * vx_s2;
		m_s3[8] <= qx_s2 * vz_s2;
		m_s3[9] <= qw_s2 * vz_s2;
		m_s3[10] <= qx_s2 * vy_s2;
		m_s3[11] <= qy_s2 * vx_s2;
		qx_s3 <= qx_s2; qy_s3 <= qy_s2; qz_s3 <= qz_s2; qw_s3 <= qw_s2;

		tw_s4 <= TW'(rnd_add(tws) >>> 24);
		tx_s4 <= TW'(rnd_add(txs) >>> 24);
		ty_s4 <= TW'(rnd_add(tys) >>> 24);
		tz_s4 <= TW'(rnd_add(tzs) >>> 24);
		qx_s4 <= qx_s3; qy_s4 <= qy_s3; qz_s4 <= qz_s3; qw_s4 <= qw_s3;

		n_s5[0] <= tx_s4 * qw_s4;
		n_s5[1] <= tw_s4 * qx_s4;
		n_s5[2] <= ty_s4 * qz_s4;
		n_s5[3] <= tz_s4 * qy_s4;
		n_s5[4] <= ty_s4 * qw_s4;
		n_s5[5] <= tw_s4 * qy_s4;
		n_s5[6] <= tz_s4 * qx_s4;
		n_s5[7] <= tx_s4 * qz_s4;
		n_s5[8] <= tz_s4 * qw_s4;
		n_s5[9] <= tw_s4 * qz_s4;
		n_s5[10] <= tx_s4 * qy_s4;
		n_s5[11] <= ty_s4 * qx_s4;

		rx_s6 <= (SW-24)'(rnd_add(rxs) >>> 24);
		ry_s6 <= (SW-24)'(rnd_add(rys) >>> 24);
		rz_s6 <= (SW-24)'(rnd_add(rzs) >>> 24);

		rx <= sat(rx_s6);
		ry <= sat(ry_s6);
		rz <= sat(rz_s6);
	end

	assign out_valid = vl_q[6];

`ifndef NO_ASSERTIONS
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> ##7 out_valid)
		else $error("qmul valid lost");
	a_qw_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vl_q[1] |-> (qw_s2 <= 27'sd20000000 && qw_s2 >= -27'sd20000000))
		else $error("qw out of bound");
	a_noinv: assert property (@(posedge clk) disable iff (!arst_n)
		!in_valid |-> ##7 !out_valid)
		else $error("qmul invented valid");
`endif
endmodule

### design/quaternion_vector_rotate_unit.sv
// Quaternion rotation of a 3D vector. The CORDIC runs TRIG_ITERATIONS (capped
// at 24) iterations; one word accepted every cycle, busy is
// always low. Throughput is set by the fully pipelined CORDIC (one stage per
// iteration) and the staged quaternion products. The receiver cannot stall.
// Reset (arst_n, async low) clears only the valid pipeline.
module quaternion_vector_rotate_unit #(
	parameter int TRIG_ITERATIONS = qvr_pkg::TrigIterDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [qvr_pkg::AngleW-1:0] angle_deg,
	input  logic signed [qvr_pkg::AxisW-1:0] axis_x,
	input  logic signed [qvr_pkg::AxisW-1:0] axis_y,
	input  logic signed [qvr_pkg::AxisW-1:0] axis_z,
	input  logic signed [qvr_pkg::VecW-1:0] vec_x,
	input  logic signed [qvr_pkg::VecW-1:0] vec_y,
	input  logic signed [qvr_pkg::VecW-1:0] vec_z,
	output logic done,
	output logic signed [qvr_pkg::VecW-1:0] rot_x,
	output logic signed [qvr_pkg::VecW-1:0] rot_y,
	output logic signed [qvr_pkg::VecW-1:0] rot_z
);
	import qvr_pkg::*;

	carry_t cin, cout;
	logic cv;
	logic signed [CordW-1:0] s, c;

	assign busy = 1'b0;
	assign cin = '{ax: axis_x, ay: axis_y, az: axis_z, vx: vec_x, vy: vec_y, vz: vec_z};

	qvr_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .in_valid(start), .angle(angle_deg),
		.in_carry(cin), .out_valid(cv), .sin_o(s), .cos_o(c), .out_carry(cout)
	);

	qvr_qmul u_qmul (
		.clk(clk), .arst_n(arst_n), .in_valid(cv), .sin_i(s), .cos_i(c),
		.in_carry(cout), .out_valid(done), .rx(rot_x), .ry(rot_y), .rz(rot_z)
	);

`ifndef NO_ASSERTIONS
	a_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_nodone: assert property (@(posedge clk) disable iff (!arst_n)
		cv |-> ##7 done)
		else $error("done missing");
	a_nodone2: assert property (@(posedge clk) disable iff (!arst_n)
		!cv |-> ##7 !done)
		else $error("spurious done");
`endif
endmodule
